/* hdl/esfd_pkg.sv */
// Shared constants and control types for the serial EEG frame deframer.
`timescale 1ns / 1ps
package esfd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned SCALE_W  = 32;
  localparam int unsigned SCALED_W = 56;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned PROD_W   = SAMPLE_W + SCALE_W + 1;

  localparam logic [BYTE_W-1:0]  HDR0_BYTE   = 8'hC0;
  localparam logic [BYTE_W-1:0]  HDR1_BYTE   = 8'hA0;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0100_0000;

  // front end to frame buffers
  typedef struct packed {
    logic we;
    logic commit;
  } wr_ctl_t;

  // back end to frame buffers
  typedef struct packed {
    logic re;
    logic pop;
  } rd_ctl_t;

  // frame buffer status
  typedef struct packed {
    logic full;
    logic avail;
  } q_stat_t;

endpackage

/* hdl/esfd_front.sv */
// Byte parser: header hunt, sample assembly and trailer check.
`timescale 1ns / 1ps
module esfd_front
  import esfd_pkg::*;
#(
  parameter int unsigned CHANNELS      = 8,
  parameter int unsigned TRAILER_ZEROS = 6,
  parameter int unsigned CH_W          = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [BYTE_W-1:0]   byte_i,
  output wr_ctl_t             wr_ctl_o,
  output logic [CH_W-1:0]     wr_ch_o,
  output logic [SAMPLE_W-1:0] wr_data_o
);

  localparam int unsigned TZ_W = (TRAILER_ZEROS > 1) ? $clog2(TRAILER_ZEROS) : 1;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_HDR1,
    ST_SKIP,
    ST_DATA,
    ST_PAD,
    ST_TRAIL
  } state_e;

  state_e            state_q, state_d;
  logic [1:0]        trip_q, trip_d;
  logic [15:0]       partial_q, partial_d;
  logic [CH_W-1:0]   ch_q, ch_d;
  logic [TZ_W-1:0]   tz_q, tz_d;

  always_comb begin
    state_d   = state_q;
    trip_d    = trip_q;
    partial_d = partial_q;
    ch_d      = ch_q;
    tz_d      = tz_q;
    wr_ctl_o  = '0;
    if (accept_i) begin
      unique case (state_q)
        ST_HUNT: begin
          if (byte_i == HDR0_BYTE) state_d = ST_HDR1;
        end
        ST_HDR1: begin
          if (byte_i == HDR1_BYTE) begin
            state_d   = ST_SKIP;
            trip_d    = '0;
            partial_d = '0;
            ch_d      = '0;
          end else begin
            state_d = ST_HUNT;
          end
        end
        ST_SKIP: state_d = ST_DATA;
        ST_DATA: begin
          if (trip_q < 2'd2) begin
            partial_d = {partial_q[7:0], byte_i};
            trip_d    = trip_q + 2'd1;
          end else begin
            wr_ctl_o.we = 1'b1;
            trip_d      = '0;
            partial_d   = '0;
            ch_d        = ch_q + CH_W'(1);
            if (ch_q == CH_W'(CHANNELS - 1)) state_d = ST_PAD;
          end
        end
        ST_PAD: begin
          state_d = ST_TRAIL;
          tz_d    = '0;
        end
        ST_TRAIL: begin
          if (byte_i != '0) begin
            state_d = ST_HUNT;
          end else if (tz_q == TZ_W'(TRAILER_ZEROS - 1)) begin
            wr_ctl_o.commit = 1'b1;
            state_d         = ST_HUNT;
          end else begin
            tz_d = tz_q + TZ_W'(1);
          end
        end
        default: state_d = ST_HUNT;
      endcase
    end
  end

  assign wr_ch_o   = ch_q;
  assign wr_data_o = {partial_q, byte_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_HUNT;
      trip_q    <= '0;
      partial_q <= '0;
      ch_q      <= '0;
      tz_q      <= '0;
    end else begin
      state_q   <= state_d;
      trip_q    <= trip_d;
      partial_q <= partial_d;
      ch_q      <= ch_d;
      tz_q      <= tz_d;
    end
  end

endmodule

/* hdl/esfd_frame_queue.sv */
// Two-frame sample buffer between parser and result stage.
`timescale 1ns / 1ps
module esfd_frame_queue
  import esfd_pkg::*;
#(
  parameter int unsigned CH_W = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wr_ctl_t             wr_ctl_i,
  input  logic [CH_W-1:0]     wr_ch_i,
  input  logic [SAMPLE_W-1:0] wr_data_i,
  input  rd_ctl_t             rd_ctl_i,
  input  logic [CH_W-1:0]     rd_ch_i,
  output logic [SAMPLE_W-1:0] rd_data_o,
  output q_stat_t             stat_o
);

  localparam int unsigned AW    = CH_W + 1;
  localparam int unsigned DEPTH = 2 ** AW;

  logic [SAMPLE_W-1:0] mem_q [DEPTH];
  logic [SAMPLE_W-1:0] rd_data_q;
  logic [1:0]          count_q, count_d;
  logic                wr_sel_q, rd_sel_q;

  always_comb begin
    count_d = count_q;
    priority if (wr_ctl_i.commit && !rd_ctl_i.pop) begin
      count_d = count_q + 2'd1;
    end else if (!wr_ctl_i.commit && rd_ctl_i.pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      wr_sel_q <= 1'b0;
      rd_sel_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (wr_ctl_i.commit) wr_sel_q <= ~wr_sel_q;
      if (rd_ctl_i.pop)    rd_sel_q <= ~rd_sel_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_ctl_i.we) mem_q[{wr_sel_q, wr_ch_i}] <= wr_data_i;
    if (rd_ctl_i.re) rd_data_q <= mem_q[{rd_sel_q, rd_ch_i}];
  end

  assign rd_data_o    = rd_data_q;
  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.avail = (count_q != 2'd0);

endmodule

/* hdl/esfd_back.sv */
// Result stage: drains frames, scales samples, drives the output register.
`timescale 1ns / 1ps
module esfd_back
  import esfd_pkg::*;
#(
  parameter int unsigned CHANNELS = 8,
  parameter int unsigned CH_W     = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  q_stat_t             stat_i,
  input  logic [SAMPLE_W-1:0] rd_data_i,
  output rd_ctl_t             rd_ctl_o,
  output logic [CH_W-1:0]     rd_ch_o,
  input  logic [SCALE_W-1:0]  scale_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [IDX_W-1:0]    idx_o,
  output logic [SAMPLE_W-1:0] raw_o,
  output logic [SCALED_W-1:0] scaled_o,
  output logic                last_o
);

  logic                adv;
  logic                rd_last;
  logic [CH_W-1:0]     rd_ch_q;
  logic                s1_valid_q;
  logic [CH_W-1:0]     s1_ch_q;
  logic                s1_last_q;
  logic                out_valid_q;
  logic [IDX_W-1:0]    idx_q;
  logic [SAMPLE_W-1:0] raw_q;
  logic [SCALED_W-1:0] scaled_q;
  logic                last_q;
  logic [PROD_W-1:0]   prod;

  assign adv     = !out_valid_q || ready_i;
  assign rd_last = (rd_ch_q == CH_W'(CHANNELS - 1));

  assign rd_ctl_o.re  = adv && stat_i.avail;
  assign rd_ctl_o.pop = rd_ctl_o.re && rd_last;
  assign rd_ch_o      = rd_ch_q;

  // signed sample times unsigned coefficient, modulo 2^PROD_W
  assign prod = {{(PROD_W - SAMPLE_W){rd_data_i[SAMPLE_W-1]}}, rd_data_i}
              * {{(PROD_W - SCALE_W){1'b0}}, scale_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ch_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rd_ctl_o.re) rd_ch_q <= rd_last ? '0 : rd_ch_q + CH_W'(1);
      if (adv) begin
        s1_valid_q  <= stat_i.avail;
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ch_q   <= rd_ch_q;
      s1_last_q <= rd_last;
      idx_q     <= IDX_W'(s1_ch_q);
      raw_q     <= rd_data_i;
      scaled_q  <= prod[SCALED_W-1:0];
      last_q    <= s1_last_q;
    end
  end

  assign valid_o  = out_valid_q;
  assign idx_o    = idx_q;
  assign raw_o    = raw_q;
  assign scaled_o = scaled_q;
  assign last_o   = last_q;

endmodule

/* hdl/eeg_serial_frame_deframer_top.sv */
// Top level of the serial EEG frame deframer.
`timescale 1ns / 1ps
// Input stream: one received serial byte per word on s_axis. The parser hunts
// for C0 A0, skips one byte, assembles CHANNELS big-endian 24-bit samples,
// skips one byte and checks TRAILER_ZEROS zero bytes; any mismatch drops the
// frame and restarts the hunt.
// Output stream: CHANNELS words per good frame on m_axis, channel order,
// tlast on the final channel. Each carries the raw sample and the sample
// times scale_coeff (unsigned Q8.24), exact in 56 bits.
// After the last trailer byte, a frame's first word passes the read and output
// registers; then one word per cycle while m_axis_tready is high.
// Throughput: one input byte per cycle; set by the two-frame sample buffer,
// which holds a finished frame while the parser fills the other.
// Stalls: m_axis holds its word; input is held off (s_axis_tready low) only
// while both frame buffers hold undrained frames.
// Reset: parser hunting, buffers empty, scale_coeff = 1.0. scale_coeff is to be
// written through cfg_we_i / cfg_wdata_i only while idle; the block does not enforce it.
module eeg_serial_frame_deframer_top
  import esfd_pkg::*;
#(
  parameter int unsigned CHANNELS      = 8,
  parameter int unsigned TRAILER_ZEROS = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [SCALE_W-1:0] cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,  // [7:0] rx_byte
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [87:0]        m_axis_tdata,  // [2:0] channel_index, [26:3] raw_sample,
                                            // [82:27] scaled_value, [87:83] zero
  output logic               m_axis_tlast   // last_in_frame
);

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [SCALE_W-1:0]  scale_q;
  logic                accept;
  wr_ctl_t             wr_ctl;
  logic [CH_W-1:0]     wr_ch;
  logic [SAMPLE_W-1:0] wr_data;
  rd_ctl_t             rd_ctl;
  logic [CH_W-1:0]     rd_ch;
  logic [SAMPLE_W-1:0] rd_data;
  q_stat_t             q_stat;
  logic [IDX_W-1:0]    idx;
  logic [SAMPLE_W-1:0] raw;
  logic [SCALED_W-1:0] scaled;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready = !q_stat.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  esfd_front #(
    .CHANNELS     (CHANNELS),
    .TRAILER_ZEROS(TRAILER_ZEROS),
    .CH_W         (CH_W)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .wr_ctl_o (wr_ctl),
    .wr_ch_o  (wr_ch),
    .wr_data_o(wr_data)
  );

  esfd_frame_queue #(
    .CH_W(CH_W)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_ctl_i (wr_ctl),
    .wr_ch_i  (wr_ch),
    .wr_data_i(wr_data),
    .rd_ctl_i (rd_ctl),
    .rd_ch_i  (rd_ch),
    .rd_data_o(rd_data),
    .stat_o   (q_stat)
  );

  esfd_back #(
    .CHANNELS(CHANNELS),
    .CH_W    (CH_W)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .stat_i   (q_stat),
    .rd_data_i(rd_data),
    .rd_ctl_o (rd_ctl),
    .rd_ch_o  (rd_ch),
    .scale_i  (scale_q),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .idx_o    (idx),
    .raw_o    (raw),
    .scaled_o (scaled),
    .last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, scaled, raw, idx};

`ifndef SYNTHESIS
  a_commit_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_ctl.commit |-> !q_stat.full)
    else $error("frame committed into full buffer");

  a_pop_needs_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_ctl.re |-> q_stat.avail)
    else $error("read from empty buffer");

  a_last_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[2:0] == IDX_W'(CHANNELS - 1)))
    else $error("tlast on wrong channel");
`endif

endmodule

/* test/esfd_frame_checker.sv */
// Checker for the serial EEG frame deframer: predicts sample words and compares them.
`timescale 1ns / 1ps
module esfd_frame_checker
  import esfd_pkg::*;
#(
  parameter int unsigned CHANNELS      = 8,
  parameter int unsigned TRAILER_ZEROS = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [SCALE_W-1:0] cfg_wdata_i,
  input  logic               s_tvalid_i,
  input  logic               s_tready_i,
  input  logic [7:0]         s_tdata_i,
  input  logic               m_tvalid_i,
  input  logic               m_tready_i,
  input  logic [87:0]        m_tdata_i,
  input  logic               m_tlast_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int PH_HUNT       = 0;
  localparam int PH_HDR1       = 1;
  localparam int PH_SKIP       = 2;
  localparam int PH_DATA       = 3;
  localparam int PH_PAD        = PH_DATA + 3 * CHANNELS;
  localparam int PH_TRAIL      = PH_PAD + 1;
  localparam int PH_TRAIL_LAST = PH_PAD + TRAILER_ZEROS;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic [IDX_W-1:0]    chan;
    logic [SAMPLE_W-1:0] raw;
    logic [SCALED_W-1:0] scaled;
    logic                last;
  } sample_word_t;

  logic [SCALE_W-1:0]  scale;
  int                  phase;
  int                  tri_pos;
  logic [15:0]         partial;
  int                  chan_cnt;
  logic [SAMPLE_W-1:0] sample_store [CHANNELS];
  sample_word_t        expected_samples_q [$];
  int                  reports;

  task automatic parse_rx_byte(input logic [7:0] b);
    sample_word_t       w;
    logic signed [63:0] raw_ext;
    logic signed [63:0] prod;
    if (phase == PH_HUNT) begin
      if (b == HDR0_BYTE) phase = PH_HDR1;
    end else if (phase == PH_HDR1) begin
      if (b == HDR1_BYTE) begin
        phase    = PH_SKIP;
        chan_cnt = 0;
        tri_pos  = 0;
        partial  = '0;
      end else begin
        phase = PH_HUNT;
      end
    end else if (phase == PH_SKIP) begin
      phase = PH_DATA;
    end else if (phase < PH_PAD) begin
      if (tri_pos < 2) begin
        partial = {partial[7:0], b};
        tri_pos++;
      end else begin
        if (chan_cnt < CHANNELS) sample_store[chan_cnt] = {partial, b};
        chan_cnt++;
        tri_pos = 0;
        partial = '0;
      end
      phase++;
    end else if (phase == PH_PAD) begin
      phase = PH_TRAIL;
    end else if (phase <= PH_TRAIL_LAST) begin
      if (b != 8'h00) begin
        phase = PH_HUNT;
      end else if (phase == PH_TRAIL_LAST) begin
        for (int k = 0; k < CHANNELS; k++) begin
          raw_ext  = {{40{sample_store[k][SAMPLE_W-1]}}, sample_store[k]};
          prod     = raw_ext * $signed({32'd0, scale});
          w.chan   = IDX_W'(k);
          w.raw    = sample_store[k];
          w.scaled = prod[SCALED_W-1:0];
          w.last   = (k == CHANNELS - 1);
          expected_samples_q.push_back(w);
        end
        phase = PH_HUNT;
      end else begin
        phase++;
      end
    end else begin
      phase = PH_HUNT;
    end
  endtask

  task automatic check_sample_word();
    sample_word_t got;
    sample_word_t exp_w;
    got.chan   = m_tdata_i[2:0];
    got.raw    = m_tdata_i[26:3];
    got.scaled = m_tdata_i[82:27];
    got.last   = m_tlast_i;
    if (expected_samples_q.size() == 0) begin
      fail_count_o++;
      if (reports < REPORT_MAX) begin
        reports++;
        $display("unexpected sample word: ch %0d raw %h scaled %h last %b",
                 got.chan, got.raw, got.scaled, got.last);
      end
    end else begin
      exp_w = expected_samples_q.pop_front();
      if (got.chan !== exp_w.chan || got.raw !== exp_w.raw ||
          got.scaled !== exp_w.scaled || got.last !== exp_w.last) begin
        fail_count_o++;
        if (reports < REPORT_MAX) begin
          reports++;
          $display("sample mismatch: exp ch %0d raw %h scaled %h last %b",
                   exp_w.chan, exp_w.raw, exp_w.scaled, exp_w.last);
          $display("                 got ch %0d raw %h scaled %h last %b",
                   got.chan, got.raw, got.scaled, got.last);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      scale        = SCALE_RESET;
      phase        = PH_HUNT;
      tri_pos      = 0;
      partial      = '0;
      chan_cnt     = 0;
      fail_count_o = 0;
      reports      = 0;
      expected_samples_q.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) check_sample_word();
      if (s_tvalid_i && s_tready_i) parse_rx_byte(s_tdata_i);
      if (cfg_we_i) scale = cfg_wdata_i;
    end
    pending_o = expected_samples_q.size();
  end

endmodule

/* test/eeg_serial_frame_deframer_top_tb.sv */
// Testbench top for the serial EEG frame deframer: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module eeg_serial_frame_deframer_top_tb;
  import esfd_pkg::*;

  localparam int CHANNELS      = 8;
  localparam int TRAILER_ZEROS = 6;
  localparam int DRAIN_CYCLES  = 16;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int RANDOM_BYTES  = 450;
  localparam int PHASE_BYTES   = 70;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_HDR,
    FRAME_BAD_TRAILER,
    FRAME_TRUNCATED
  } frame_fault_e;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [SCALE_W-1:0] cfg_wdata_i   = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [87:0]        m_axis_tdata;
  logic               m_axis_tlast;

  int                  fail_count;
  int                  pending;
  int                  bytes_sent  = 0;
  int                  good_frames = 0;
  int                  burst_left  = 0;
  int                  stall_mode  = 0;
  int                  mode_left   = 0;
  logic [SAMPLE_W-1:0] frame_samples [CHANNELS];

  eeg_serial_frame_deframer_top #(
    .CHANNELS     (CHANNELS),
    .TRAILER_ZEROS(TRAILER_ZEROS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  esfd_frame_checker #(
    .CHANNELS     (CHANNELS),
    .TRAILER_ZEROS(TRAILER_ZEROS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tlast_i   (m_axis_tlast),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #400000;
    $display("Test completed with failures");
    $finish;
  end

  // receiver: ready always, at random, or mostly stalled, in stretches
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic push_byte(input logic [7:0] b);
    int   gap;
    logic rdy;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk_i);
      n++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_scale(input logic [SCALE_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // frame from frame_samples; bad_byte is the wrong header or trailer byte
  task automatic send_frame(input frame_fault_e fault, input logic [7:0] bad_byte);
    int trunc_at;
    int bad_pos;
    int n;
    trunc_at = (fault == FRAME_TRUNCATED) ? $urandom_range(0, 3 * CHANNELS - 1) : -1;
    bad_pos  = (fault == FRAME_BAD_TRAILER) ? $urandom_range(0, TRAILER_ZEROS - 1) : -1;
    n = 0;
    push_byte(HDR0_BYTE);
    if (fault == FRAME_BAD_HDR) begin
      push_byte(bad_byte);
      return;
    end
    push_byte(HDR1_BYTE);
    push_byte(8'($urandom_range(0, 255)));
    for (int c = 0; c < CHANNELS; c++) begin
      for (int j = 2; j >= 0; j--) begin
        if (n == trunc_at) return;
        push_byte(frame_samples[c][8*j +: 8]);
        n++;
      end
    end
    push_byte(8'($urandom_range(0, 255)));
    for (int t = 0; t < TRAILER_ZEROS; t++) begin
      push_byte((t == bad_pos) ? bad_byte : 8'h00);
      if (t == bad_pos) return;
    end
    if (fault == FRAME_GOOD) good_frames++;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: pick_sample = 24'h7FFFFF;
      1: pick_sample = 24'h800000;
      2: pick_sample = 24'h000000;
      3: pick_sample = 24'hFFFFFF;
      default: pick_sample = 24'($urandom);
    endcase
  endfunction

  task automatic send_random_phase();
    int           start;
    int           r;
    frame_fault_e fault;
    logic [7:0]   bad;
    start = bytes_sent;
    while (bytes_sent - start < PHASE_BYTES) begin
      if ($urandom_range(0, 1) == 0) begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
      end
      foreach (frame_samples[c]) frame_samples[c] = pick_sample();
      r = $urandom_range(0, 9);
      fault = (r < 7) ? FRAME_GOOD : (r == 7) ? FRAME_BAD_HDR :
              (r == 8) ? FRAME_BAD_TRAILER : FRAME_TRUNCATED;
      bad = ($urandom_range(0, 3) == 0) ? HDR0_BYTE : 8'($urandom_range(1, 255));
      if (fault == FRAME_BAD_HDR && bad == HDR1_BYTE) bad = HDR0_BYTE;
      send_frame(fault, bad);
    end
  endtask

  initial begin
    logic [SCALE_W-1:0] scale_pick;
    int                 p;
    p = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // header hiccup: a repeated C0 is not rechecked, so the A0 is ignored
    push_byte(HDR0_BYTE);
    push_byte(HDR0_BYTE);
    push_byte(HDR1_BYTE);
    frame_samples[0] = 24'h7FFFFF;
    frame_samples[1] = 24'h800000;
    frame_samples[2] = 24'h000000;
    frame_samples[3] = 24'hFFFFFF;
    frame_samples[4] = 24'h000001;
    frame_samples[5] = 24'h555555;
    frame_samples[6] = 24'hAAAAAA;
    frame_samples[7] = 24'h800001;
    send_frame(FRAME_GOOD, 8'h00);
    // dropped on a C0 trailer byte; the following A0 must not complete a header
    send_frame(FRAME_BAD_TRAILER, HDR0_BYTE);
    push_byte(HDR1_BYTE);
    // back to back: the byte after the trailer starts the next header
    send_frame(FRAME_GOOD, 8'h00);
    send_frame(FRAME_GOOD, 8'h00);

    while (p < 4 || bytes_sent < RANDOM_BYTES || good_frames < 10) begin
      wait_drained();
      case (p)
        0: scale_pick = 32'hFFFF_FFFF;
        1: scale_pick = 32'h0000_0000;
        2: scale_pick = 32'h0000_0001;
        3: scale_pick = SCALE_RESET;
        default: scale_pick = $urandom;
      endcase
      write_scale(scale_pick);
      send_random_phase();
      p++;
    end
    wait_drained();

    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/esfd_pkg.sv
hdl/esfd_front.sv
hdl/esfd_frame_queue.sv
hdl/esfd_back.sv
hdl/eeg_serial_frame_deframer_top.sv
test/esfd_frame_checker.sv
test/eeg_serial_frame_deframer_top_tb.sv
